// ===== hdl/skf_pkg.sv =====
`timescale 1ns / 1ps

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 25;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 96;

  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 2'd2;

  localparam logic [DATA_W-1:0] PROC_NOISE_RST = 32'd16777;
  localparam logic [DATA_W-1:0] MEAS_NOISE_RST = 32'd167772;
  localparam logic [DATA_W-1:0] INIT_EST_RST   = 32'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } skf_state_t;

endpackage

// ===== hdl/scalar_kalman_filter.sv =====
`timescale 1ns / 1ps

// One-dimensional Kalman filter with a constant-state model. Each input word
// carries a signed Q16.16 measurement; each result word carries the new
// estimate (Q16.16), the gain of the step (Q1.24 at FRAC_BITS = 24) and the
// updated error variance (saturating). One item is worked on at a time: the
// gain comes from a bit-serial restoring divider and the estimate and
// variance updates from two bit-serial shift-add multipliers run side by
// side. A finished result waits in the output register while the next item
// is taken. A write to any of the three configuration registers reloads the
// estimate from initial_estimate and sets the variance to 1.0; writes belong
// in idle periods only.

module scalar_kalman_filter #(
  parameter int FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [skf_pkg::IN_W-1:0]         in_tdata,   // measurement
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [skf_pkg::OUT_W-1:0]        out_tdata,  // estimate, gain, error_variance
  input  logic                             cfg_wen,
  input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]       cfg_wdata
);

  import skf_pkg::*;

  localparam int GW = FRAC_BITS + 1;
  localparam int EW = DATA_W + 1;
  localparam logic [GW-1:0] ONE_FX = GW'(1) << FRAC_BITS;

  skf_state_t state_r, state_nxt;

  logic [DATA_W-1:0] pn_r, mn_r, ie_r;
  logic [DATA_W-1:0] est_r, est_nxt;
  logic [DATA_W-1:0] var_r, var_nxt;
  logic [DATA_W-1:0] meas_r;
  logic [DATA_W-1:0] p_r;
  logic              den_zero_r, full_r, neg_r;
  logic [EW-1:0]     mag_r;
  logic [GW-1:0]     gain_r;
  logic [DATA_W-1:0] out_est_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic [DATA_W-1:0] out_var_r;
  logic              out_tvalid_r, out_tvalid_nxt;

  logic              div_start, mul_start, fin_go, cfg_hit;
  logic              div_busy, mul_e_busy, mul_v_busy;
  logic [FRAC_BITS-1:0] quot;
  logic [EW-1:0]     p_sum, den, diff, mag;
  logic [DATA_W-1:0] p_sat;
  logic [GW-1:0]     gain_nxt, one_minus_gain;
  logic [EW+GW-1:0]  est_prod;
  logic [DATA_W+GW-1:0] var_prod;
  logic [EW-1:0]     delta, var_sum;
  logic [DATA_W-1:0] est_new, var_new;
  logic [63:0]       gain_wide;

  skf_div_serial #(
    .NW(DATA_W),
    .DW(EW),
    .QW(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (p_r),
    .den  (den),
    .busy (div_busy),
    .quot (quot)
  );

  skf_mul_serial #(
    .AW(EW),
    .BW(GW)
  ) u_mul_est (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mag_r),
    .b    (gain_nxt),
    .busy (mul_e_busy),
    .prod (est_prod)
  );

  skf_mul_serial #(
    .AW(DATA_W),
    .BW(GW)
  ) u_mul_var (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (p_r),
    .b    (one_minus_gain),
    .busy (mul_v_busy),
    .prod (var_prod)
  );

  // datapath
  always_comb begin
    p_sum = {1'b0, var_r} + {1'b0, pn_r};
    p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    den   = {1'b0, p_r} + {1'b0, mn_r};
    diff  = {meas_r[DATA_W-1], meas_r} - {est_r[DATA_W-1], est_r};
    mag   = diff[EW-1] ? (~diff + EW'(1)) : diff;

    if (den_zero_r) begin
      gain_nxt = '0;
    end else if (full_r) begin
      gain_nxt = ONE_FX;
    end else begin
      gain_nxt = {1'b0, quot};
    end
    one_minus_gain = ONE_FX - gain_nxt;

    // round half up: add the bit just below the cut
    delta   = est_prod[FRAC_BITS +: EW] + EW'(est_prod[FRAC_BITS-1]);
    est_new = neg_r ? (est_r - delta[DATA_W-1:0]) : (est_r + delta[DATA_W-1:0]);
    var_sum = var_prod[FRAC_BITS +: EW] + EW'(var_prod[FRAC_BITS-1]);
    var_new = var_sum[DATA_W] ? '1 : var_sum[DATA_W-1:0];

    gain_wide = 64'(gain_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!mul_e_busy && !mul_v_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and register updates
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_DEN);
    mul_start = (state_r == ST_DIV) && !div_busy;
    fin_go    = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);
    cfg_hit   = cfg_wen && ((cfg_index == REG_PROC_NOISE) ||
                            (cfg_index == REG_MEAS_NOISE) ||
                            (cfg_index == REG_INIT_EST));

    est_nxt        = est_r;
    var_nxt        = var_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (fin_go) begin
      est_nxt        = est_new;
      var_nxt        = var_new;
      out_tvalid_nxt = 1'b1;
    end
    if (cfg_hit) begin
      est_nxt = (cfg_index == REG_INIT_EST) ? cfg_wdata : ie_r;
      var_nxt = DATA_W'(ONE_FX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      pn_r         <= PROC_NOISE_RST;
      mn_r         <= MEAS_NOISE_RST;
      ie_r         <= INIT_EST_RST;
      est_r        <= INIT_EST_RST;
      var_r        <= DATA_W'(ONE_FX);
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      est_r        <= est_nxt;
      var_r        <= var_nxt;
      if (cfg_wen && (cfg_index == REG_PROC_NOISE)) begin
        pn_r <= cfg_wdata;
      end
      if (cfg_wen && (cfg_index == REG_MEAS_NOISE)) begin
        mn_r <= cfg_wdata;
      end
      if (cfg_wen && (cfg_index == REG_INIT_EST)) begin
        ie_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      meas_r <= in_tdata[DATA_W-1:0];
    end
    if (state_r == ST_PRED) begin
      p_r <= p_sat;
    end
    if (state_r == ST_DEN) begin
      den_zero_r <= (den == '0);
      full_r     <= (mn_r == '0) && (den != '0);
      neg_r      <= diff[EW-1];
      mag_r      <= mag;
    end
    if (mul_start) begin
      gain_r <= gain_nxt;
    end
    if (fin_go) begin
      out_est_r  <= est_new;
      out_gain_r <= gain_wide[GAIN_W-1:0];
      out_var_r  <= var_new;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_W - 2 * DATA_W - GAIN_W)'(0), out_var_r, out_gain_r, out_est_r};

endmodule

// ===== hdl/skf_div_serial.sv =====
`timescale 1ns / 1ps

module skf_div_serial #(
  parameter int NW = 32,
  parameter int DW = 33,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DW:0]   rem_r;
  logic [DW:0]   rem_nxt;
  logic [DW-1:0] den_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_r[DW-1:0], 1'b0};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});
  assign rem_nxt = fits ? trial : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(QW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= (DW + 1)'(num);
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[QW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

// ===== hdl/skf_mul_serial.sv =====
`timescale 1ns / 1ps

module skf_mul_serial #(
  parameter int AW = 32,
  parameter int BW = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [AW-1:0] hi_r;
  logic [BW-1:0] lo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [AW:0]   sum;

  // shift-add, multiplier bits taken lsb first
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(BW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[AW:1];
      lo_r <= {sum[0], lo_r[BW-1:1]};
    end
  end

  assign busy = busy_r;
  assign prod = {hi_r, lo_r};

endmodule

// ===== tb/scalar_kalman_filter_test.sv =====
`timescale 1ns / 1ps

module scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int FRAC = 24;
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC;
  localparam logic [63:0] HALF_FX = 64'd1 << (FRAC - 1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * FRAC + 16;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 175;

  typedef struct packed {
    logic [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0] gain;
    logic [DATA_W-1:0] variance;
  } kalman_result_t;

  class kalman_scoreboard;
    logic [DATA_W-1:0] proc_noise;
    logic [DATA_W-1:0] meas_noise;
    logic [DATA_W-1:0] init_estimate;
    logic [DATA_W-1:0] estimate;
    logic [DATA_W-1:0] variance;
    kalman_result_t predicted_steps[$];
    int errors;
    int results_seen;
    int measurements_seen;

    function new();
      proc_noise = PROC_NOISE_RST;
      meas_noise = MEAS_NOISE_RST;
      init_estimate = INIT_EST_RST;
      estimate = INIT_EST_RST;
      variance = ONE_FX[DATA_W-1:0];
      errors = 0;
      results_seen = 0;
      measurements_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_PROC_NOISE: proc_noise = val;
        REG_MEAS_NOISE: meas_noise = val;
        REG_INIT_EST: init_estimate = val;
        default: return;
      endcase
      estimate = init_estimate;
      variance = ONE_FX[DATA_W-1:0];
    endfunction

    function kalman_result_t filter_update(logic [DATA_W-1:0] meas);
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] gain;
      logic [63:0] diff;
      logic [63:0] mag;
      logic [63:0] delta;
      logic [63:0] vnew;
      kalman_result_t r;
      p = {32'd0, variance} + {32'd0, proc_noise};
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      den = p + {32'd0, meas_noise};
      gain = (den != 0) ? (p << FRAC) / den : 64'd0;
      if (gain > ONE_FX) gain = ONE_FX;
      diff = {{32{meas[31]}}, meas} - {{32{estimate[31]}}, estimate};
      mag = diff[63] ? -diff : diff;
      delta = (mag * gain + HALF_FX) >> FRAC;
      if (diff[63]) estimate = estimate - delta[31:0];
      else estimate = estimate + delta[31:0];
      vnew = ((ONE_FX - gain) * p + HALF_FX) >> FRAC;
      variance = vnew[31:0];
      r.estimate = estimate;
      r.gain = gain[GAIN_W-1:0];
      r.variance = variance;
      return r;
    endfunction

    function void note_measurement(logic [IN_W-1:0] meas);
      measurements_seen++;
      predicted_steps.push_back(filter_update(meas));
    endfunction

    function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s at result %0d: expected %h, got %h",
                 what, results_seen, want, got);
    endfunction

    function void check_output(logic [OUT_W-1:0] word);
      kalman_result_t want;
      kalman_result_t got;
      got = word[DATA_W+GAIN_W+DATA_W-1:0];
      got.estimate = word[DATA_W-1:0];
      got.gain = word[DATA_W+GAIN_W-1:DATA_W];
      got.variance = word[2*DATA_W+GAIN_W-1:DATA_W+GAIN_W];
      results_seen++;
      if (predicted_steps.size() == 0) begin
        report("unexpected word", '0, got.estimate);
        return;
      end
      want = predicted_steps.pop_front();
      if (got.estimate !== want.estimate) report("estimate", want.estimate, got.estimate);
      if (got.gain !== want.gain) report("gain", 32'(want.gain), 32'(got.gain));
      if (got.variance !== want.variance) report("variance", want.variance, got.variance);
    endfunction

    function int pending();
      return predicted_steps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  int cycles = 0;
  int settings_used = 1;
  kalman_scoreboard board = new();

  scalar_kalman_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, board.pending());
      $display("[scalar_kalman_filter] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (out_gaps_on) out_tready <= ($urandom_range(99) >= 8);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_output(out_tdata);
  end

  task automatic send_measurement(input logic [IN_W-1:0] meas);
    @(negedge clk);
    while (in_gaps_on && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= meas;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_measurement(meas);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] pn, input logic [DATA_W-1:0] mn,
                               input logic [DATA_W-1:0] ie);
    settle();
    write_reg(REG_PROC_NOISE, pn);
    write_reg(REG_MEAS_NOISE, mn);
    write_reg(REG_INIT_EST, ie);
    settings_used++;
  endtask

  function automatic logic [DATA_W-1:0] pick_setting(logic [CFG_IDX_W-1:0] idx);
    if (idx == REG_INIT_EST) begin
      case ($urandom_range(7))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        default: return $urandom();
      endcase
    end
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_measurement(logic [IN_W-1:0] center);
    case ($urandom_range(19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return center + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  initial begin
    logic [CFG_IDX_W-1:0] reg_list [3];
    logic [IN_W-1:0] center;
    bit wrote;
    reg_list = '{REG_PROC_NOISE, REG_MEAS_NOISE, REG_INIT_EST};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, field extremes
    send_measurement(32'h0000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'hFFFF_FFFF);
    send_measurement(32'h0000_0001);
    send_measurement(32'h0001_0000);

    // predicted variance saturates, gain stays at one
    load_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h0000_0000);

    // both noises zero: variance falls to zero, then divisor is zero
    load_settings(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h0000_0005);
    send_measurement(32'h8000_0000);

    // widest divisor, plus a write to the unused index
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h1234_5678);

    // heavy measurement noise, tiny gain
    load_settings(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h0000_0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      in_gaps_on = (ph != 3 && ph != 4);
      out_gaps_on = (ph != 3 && ph != 4);
      wrote = 1'b0;
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(1) == 1 || (r == 2 && !wrote)) begin
          write_reg(reg_list[r], pick_setting(reg_list[r]));
          wrote = 1'b1;
        end
      end
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom());
      settings_used++;
      center = $urandom();
      repeat (PHASE_ITEMS) send_measurement(pick_measurement(center));
    end

    settle();
    $display("sent %0d measurements under %0d filter settings, %0d result words checked",
             board.measurements_seen, settings_used, board.results_seen);
    $display("%0d mismatches", board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[scalar_kalman_filter] OK");
    end else begin
      $display("[scalar_kalman_filter] ERROR");
    end
    $finish;
  end

endmodule
